// ===== design/kbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step package
// Shared Q16.16 types, constants and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package kbs_pkg;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t pos_x;
    q_t pos_y;
    q_t heading;
    q_t speed;
    q_t accel;
    q_t steer;
  } kbs_state_t;

  typedef struct packed {
    q_t jerk;
    q_t steer_rate;
  } kbs_ctrl_t;

  typedef enum logic [1:0] {
    CFG_MODE      = 2'd0,
    CFG_TIME_STEP = 2'd1,
    CFG_INV_WB    = 2'd2
  } kbs_cfg_idx_e;

  localparam int KBS_SC_W      = 19;
  localparam int KBS_Z_W       = 20;
  localparam int KBS_WRAP_LAT  = 3;
  localparam int KBS_DIV_NW    = KBS_SC_W - 1 + 16;
  localparam int KBS_DIV_LAT   = KBS_DIV_NW + 2;

  localparam q_t KBS_Q_MAX = 32'sh7FFFFFFF;
  localparam q_t KBS_Q_MIN = 32'sh80000000;

  localparam logic signed [KBS_Z_W-1:0] KBS_PI      = 20'sd205887;
  localparam logic signed [KBS_Z_W-1:0] KBS_HALF_PI = 20'sd102944;
  localparam logic [18:0]               KBS_TWO_PI  = 19'd411775;
  localparam logic [33:0]               KBS_WRAP_OFS   = 34'd2148024287;
  localparam logic [21:0]               KBS_WRAP_RECIP = 22'd2670175;
  localparam logic signed [31:0]        KBS_CORDIC_GAIN = 32'sd652032874;

  function automatic logic signed [KBS_Z_W-1:0] kbs_atan(int i);
    logic signed [KBS_Z_W-1:0] r;
    case (i)
      0:  r = 20'sd51472;
      1:  r = 20'sd30386;
      2:  r = 20'sd16055;
      3:  r = 20'sd8150;
      4:  r = 20'sd4091;
      5:  r = 20'sd2047;
      6:  r = 20'sd1024;
      7:  r = 20'sd512;
      8:  r = 20'sd256;
      9:  r = 20'sd128;
      10: r = 20'sd64;
      11: r = 20'sd32;
      12: r = 20'sd16;
      13: r = 20'sd8;
      14: r = 20'sd4;
      15: r = 20'sd2;
      16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q_t kbs_qadd(q_t a, q_t b);
    logic signed [32:0] s;
    q_t r;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) begin
      r = KBS_Q_MAX;
    end else if (s < -33'sd2147483648) begin
      r = KBS_Q_MIN;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic q_t kbs_qmul(q_t a, q_t b);
    logic signed [63:0] p;
    logic signed [47:0] h;
    q_t r;
    p = 64'(a) * 64'(b);
    h = p[63:16];
    if (h > 48'sd2147483647) begin
      r = KBS_Q_MAX;
    end else if (h < -48'sd2147483648) begin
      r = KBS_Q_MIN;
    end else begin
      r = h[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/kbs_if.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step channels
// Input state beat and output state beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kbs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] speed;
  logic signed [31:0] accel;
  logic signed [31:0] steer;
  logic signed [31:0] jerk;
  logic signed [31:0] steer_rate;

  modport source (output valid, pos_x, pos_y, heading, speed, accel, steer, jerk,
                  steer_rate, input ready);
  modport sink (input valid, pos_x, pos_y, heading, speed, accel, steer, jerk,
                steer_rate, output ready);
endinterface

interface kbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_pos_x;
  logic signed [31:0] next_pos_y;
  logic signed [31:0] next_heading;
  logic signed [31:0] next_speed;
  logic signed [31:0] next_accel;
  logic signed [31:0] next_steer;

  modport source (output valid, next_pos_x, next_pos_y, next_heading, next_speed,
                  next_accel, next_steer, input ready);
  modport sink (input valid, next_pos_x, next_pos_y, next_heading, next_speed,
                next_accel, next_steer, output ready);
endinterface

// ===== design/kbs_delay.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step delay line
// Enabled shift register that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module kbs_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        sr_q[k] <= '0;
      end
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[N-1];
endmodule

// ===== design/kbs_wrap.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step angle wrap
// Three-stage reduction of a Q16.16 angle into [-pi, pi] by reciprocal multiply.
// ----------------------------------------------------------------------------
module kbs_wrap (
  input  logic        clk_i,
  input  logic        en_i,
  input  kbs_pkg::q_t a_i,
  output kbs_pkg::q_t w_o
);
  import kbs_pkg::*;

  logic [33:0] u34;
  logic [46:0] prod;
  logic [32:0] u1_q, u2_q;
  logic [46:0] prod_q;
  logic [33:0] qc_q;
  logic [33:0] r34;
  logic [KBS_Z_W-1:0] r20, r2;
  logic signed [KBS_Z_W-1:0] w_d;
  q_t w_q;

  assign u34  = {{2{a_i[31]}}, a_i} + KBS_WRAP_OFS;
  assign prod = 47'(u34[32:8]) * 47'(KBS_WRAP_RECIP);
  assign r34  = {1'b0, u2_q} - qc_q;
  assign r20  = r34[KBS_Z_W-1:0];
  assign r2   = (r20 >= 20'(KBS_TWO_PI)) ? r20 - 20'(KBS_TWO_PI) : r20;
  assign w_d  = $signed(r2) - KBS_PI;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q   <= u34[32:0];
      prod_q <= prod;
      u2_q   <= u1_q;
      qc_q   <= 34'(prod_q[46:32]) * 34'(KBS_TWO_PI);
      w_q    <= 32'(w_d);
    end
  end

  assign w_o = w_q;
endmodule

// ===== design/kbs_cordic.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step CORDIC
// Pipelined rotation-mode CORDIC giving sine and cosine, one iteration a stage.
// ----------------------------------------------------------------------------
module kbs_cordic #(
  parameter int ITERS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  kbs_pkg::q_t                          angle_i,
  output logic signed [kbs_pkg::KBS_SC_W-1:0] sin_o,
  output logic signed [kbs_pkg::KBS_SC_W-1:0] cos_o
);
  import kbs_pkg::*;

  q_t wz;
  logic signed [KBS_Z_W-1:0] z0;
  logic signed [31:0] x_q [ITERS+1];
  logic signed [31:0] y_q [ITERS+1];
  logic signed [KBS_Z_W-1:0] z_q [ITERS+1];
  logic flip_q [ITERS+1];
  logic signed [31:0] ys, xs;
  logic signed [KBS_SC_W-1:0] sin_q, cos_q;

  kbs_wrap u_wrap (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (angle_i),
    .w_o   (wz)
  );

  assign z0 = wz[KBS_Z_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= KBS_CORDIC_GAIN;
      y_q[0] <= '0;
      if (z0 > KBS_HALF_PI) begin
        z_q[0]    <= z0 - KBS_PI;
        flip_q[0] <= 1'b1;
      end else if (z0 < -KBS_HALF_PI) begin
        z_q[0]    <= z0 + KBS_PI;
        flip_q[0] <= 1'b1;
      end else begin
        z_q[0]    <= z0;
        flip_q[0] <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    logic signed [31:0] dx, dy;
    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[k+1] <= flip_q[k];
        if (!z_q[k][KBS_Z_W-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - kbs_atan(k);
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + kbs_atan(k);
        end
      end
    end
  end

  assign ys = y_q[ITERS] >>> 14;
  assign xs = x_q[ITERS] >>> 14;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (flip_q[ITERS]) begin
        sin_q <= -ys[KBS_SC_W-1:0];
        cos_q <= -xs[KBS_SC_W-1:0];
      end else begin
        sin_q <= ys[KBS_SC_W-1:0];
        cos_q <= xs[KBS_SC_W-1:0];
      end
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

// ===== design/kbs_div.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step tangent divider
// Pipelined restoring divider forming sin/cos in Q16.16, one quotient bit a stage.
// ----------------------------------------------------------------------------
module kbs_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [kbs_pkg::KBS_SC_W-1:0] sin_i,
  input  logic signed [kbs_pkg::KBS_SC_W-1:0] cos_i,
  output kbs_pkg::q_t                          tan_o
);
  import kbs_pkg::*;

  localparam int NW = KBS_DIV_NW;
  localparam int DW = KBS_SC_W - 1;

  typedef struct packed {
    logic neg;
    logic cz;
    logic sp;
    logic sn;
  } kbs_div_flags_t;

  logic signed [KBS_SC_W-1:0] ns, nc;
  logic [DW-1:0] mag_s, mag_c;
  logic [NW-1:0] num_q [NW+1];
  logic [DW-1:0] rem_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  kbs_div_flags_t fl_q [NW+1];
  q_t tan_q;
  logic [NW-1:0] quo;

  assign ns    = -sin_i;
  assign nc    = -cos_i;
  assign mag_s = sin_i[KBS_SC_W-1] ? ns[DW-1:0] : sin_i[DW-1:0];
  assign mag_c = cos_i[KBS_SC_W-1] ? nc[DW-1:0] : cos_i[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]    <= {mag_s, 16'b0};
      rem_q[0]    <= '0;
      den_q[0]    <= mag_c;
      fl_q[0].neg <= sin_i[KBS_SC_W-1] ^ cos_i[KBS_SC_W-1];
      fl_q[0].cz  <= (cos_i == '0);
      fl_q[0].sp  <= !sin_i[KBS_SC_W-1] && (sin_i != '0);
      fl_q[0].sn  <= sin_i[KBS_SC_W-1];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] diff;
    assign t    = {rem_q[k], num_q[k][NW-1]};
    assign ge   = (t >= {1'b0, den_q[k]});
    assign diff = t - {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        num_q[k+1] <= {num_q[k][NW-2:0], ge};
        den_q[k+1] <= den_q[k];
        fl_q[k+1]  <= fl_q[k];
      end
    end
  end

  assign quo = num_q[NW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fl_q[NW].cz) begin
        if (fl_q[NW].sp) begin
          tan_q <= KBS_Q_MAX;
        end else if (fl_q[NW].sn) begin
          tan_q <= KBS_Q_MIN;
        end else begin
          tan_q <= '0;
        end
      end else if (!fl_q[NW].neg) begin
        tan_q <= (quo > NW'(32'h7FFFFFFF)) ? KBS_Q_MAX : quo[31:0];
      end else begin
        tan_q <= (quo > NW'(32'h80000000)) ? KBS_Q_MIN : -quo[31:0];
      end
    end
  end

  assign tan_o = tan_q;
endmodule

// ===== design/kbs_eval.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step evaluation pass
// Computes base + factor * derivative(state) for the six state elements.
// ----------------------------------------------------------------------------
module kbs_eval #(
  parameter int ITERS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  kbs_pkg::kbs_state_t eval_i,
  input  kbs_pkg::kbs_state_t base_i,
  input  kbs_pkg::kbs_ctrl_t  ctrl_i,
  input  kbs_pkg::q_t         factor_i,
  input  kbs_pkg::q_t         inv_wb_i,
  output logic                valid_o,
  output kbs_pkg::kbs_state_t res_o,
  output kbs_pkg::kbs_state_t base_o,
  output kbs_pkg::kbs_ctrl_t  ctrl_o
);
  import kbs_pkg::*;

  localparam int CL = KBS_WRAP_LAT + ITERS + 2;
  localparam int TL = CL + KBS_DIV_LAT;

  typedef struct packed {
    q_t         speed;
    q_t         accel;
    kbs_state_t base;
    kbs_ctrl_t  ctrl;
  } kbs_side_t;

  logic signed [KBS_SC_W-1:0] hs, hc, ss, sc, hs_d, hc_d;
  q_t tan_v;
  kbs_side_t side_in, side_d;
  logic valid_d;
  kbs_side_t sd1_q, sd2_q, sd3_q, sd4_q;
  logic [3:0] vld_q;
  q_t pc_q, ps_q, pt_q;
  kbs_state_t der_q, mul_q, res_q;

  kbs_cordic #(.ITERS(ITERS)) u_cordic_head (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .angle_i (eval_i.heading),
    .sin_o   (hs),
    .cos_o   (hc)
  );

  kbs_cordic #(.ITERS(ITERS)) u_cordic_steer (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .angle_i (eval_i.steer),
    .sin_o   (ss),
    .cos_o   (sc)
  );

  kbs_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .sin_i (ss),
    .cos_i (sc),
    .tan_o (tan_v)
  );

  kbs_delay #(.W(2*KBS_SC_W), .N(KBS_DIV_LAT)) u_dly_head (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    ({hs, hc}),
    .q_o    ({hs_d, hc_d})
  );

  assign side_in = '{speed: eval_i.speed, accel: eval_i.accel, base: base_i, ctrl: ctrl_i};

  kbs_delay #(.W($bits(kbs_side_t)), .N(TL)) u_dly_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (side_in),
    .q_o    (side_d)
  );

  kbs_delay #(.W(1), .N(TL)) u_dly_vld (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (valid_i),
    .q_o    (valid_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd1_q <= side_d;
      pc_q  <= kbs_qmul(side_d.speed, 32'(hc_d));
      ps_q  <= kbs_qmul(side_d.speed, 32'(hs_d));
      pt_q  <= kbs_qmul(side_d.speed, tan_v);

      sd2_q              <= sd1_q;
      der_q.pos_x        <= pc_q;
      der_q.pos_y        <= ps_q;
      der_q.heading      <= kbs_qmul(pt_q, inv_wb_i);
      der_q.speed        <= sd1_q.accel;
      der_q.accel        <= sd1_q.ctrl.jerk;
      der_q.steer        <= sd1_q.ctrl.steer_rate;

      sd3_q          <= sd2_q;
      mul_q.pos_x    <= kbs_qmul(factor_i, der_q.pos_x);
      mul_q.pos_y    <= kbs_qmul(factor_i, der_q.pos_y);
      mul_q.heading  <= kbs_qmul(factor_i, der_q.heading);
      mul_q.speed    <= kbs_qmul(factor_i, der_q.speed);
      mul_q.accel    <= kbs_qmul(factor_i, der_q.accel);
      mul_q.steer    <= kbs_qmul(factor_i, der_q.steer);

      sd4_q          <= sd3_q;
      res_q.pos_x    <= kbs_qadd(sd3_q.base.pos_x, mul_q.pos_x);
      res_q.pos_y    <= kbs_qadd(sd3_q.base.pos_y, mul_q.pos_y);
      res_q.heading  <= kbs_qadd(sd3_q.base.heading, mul_q.heading);
      res_q.speed    <= kbs_qadd(sd3_q.base.speed, mul_q.speed);
      res_q.accel    <= kbs_qadd(sd3_q.base.accel, mul_q.accel);
      res_q.steer    <= kbs_qadd(sd3_q.base.steer, mul_q.steer);
    end
  end

  assign valid_o = vld_q[3];
  assign res_o   = res_q;
  assign base_o  = sd4_q.base;
  assign ctrl_o  = sd4_q.ctrl;
endmodule

// ===== design/kinematic_bicycle_step.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step
// One Euler or midpoint step of a kinematic bicycle model in Q16.16.
//
//   Channel   Direction  Beat contents
//   in_i      sink       pos_x pos_y heading speed accel steer jerk steer_rate
//   out_o     source     next_pos_x next_pos_y next_heading next_speed
//                        next_accel next_steer
//   cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle while the skid register is empty; each beat
// runs two evaluation passes, each a CORDIC chain followed by a 34-stage divider.
// Reset clears all valid bits and loads the default configuration.
// A stalled output holds its beat; a one-entry skid register lets one more
// beat leave the pipeline before the whole pipeline stops.
// ----------------------------------------------------------------------------
module kinematic_bicycle_step #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  kbs_in_if.sink      in_i,
  kbs_out_if.source   out_o
);
  import kbs_pkg::*;

  logic        mode_q;
  logic [30:0] dt_q;
  logic [30:0] iwb_q;

  logic       en;
  kbs_state_t st;
  kbs_ctrl_t  ctrl;
  q_t         factor1, factor2, inv_wb;
  logic       v1, v2, pv;
  kbs_state_t res1, base1, res2, base2, base2_in, res2_d, fin;
  kbs_ctrl_t  ctrl1, ctrl2;
  q_t         wh, ws;
  logic       out_v_q, skid_v_q, pop;
  kbs_state_t out_d_q, skid_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      dt_q   <= 31'd6554;
      iwb_q  <= 31'd23406;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q <= cfg_data_i[0];
        CFG_TIME_STEP: dt_q   <= cfg_data_i;
        CFG_INV_WB:    iwb_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_q;
  assign in_i.ready = en;
  assign pop      = out_v_q && out_o.ready;

  assign st   = '{pos_x: in_i.pos_x, pos_y: in_i.pos_y, heading: in_i.heading,
                  speed: in_i.speed, accel: in_i.accel, steer: in_i.steer};
  assign ctrl = '{jerk: in_i.jerk, steer_rate: in_i.steer_rate};

  assign inv_wb  = {1'b0, iwb_q};
  assign factor1 = mode_q ? {2'b0, dt_q[30:1]} : {1'b0, dt_q};
  assign factor2 = mode_q ? {1'b0, dt_q} : '0;

  kbs_eval #(.ITERS(CORDIC_ITERATIONS)) u_pass1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .eval_i   (st),
    .base_i   (st),
    .ctrl_i   (ctrl),
    .factor_i (factor1),
    .inv_wb_i (inv_wb),
    .valid_o  (v1),
    .res_o    (res1),
    .base_o   (base1),
    .ctrl_o   (ctrl1)
  );

  assign base2_in = mode_q ? base1 : res1;

  kbs_eval #(.ITERS(CORDIC_ITERATIONS)) u_pass2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v1),
    .eval_i   (res1),
    .base_i   (base2_in),
    .ctrl_i   (ctrl1),
    .factor_i (factor2),
    .inv_wb_i (inv_wb),
    .valid_o  (v2),
    .res_o    (res2),
    .base_o   (base2),
    .ctrl_o   (ctrl2)
  );

  kbs_wrap u_wrap_head (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (res2.heading),
    .w_o   (wh)
  );

  kbs_wrap u_wrap_steer (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (res2.steer),
    .w_o   (ws)
  );

  kbs_delay #(.W($bits(kbs_state_t)), .N(KBS_WRAP_LAT)) u_dly_res (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (res2),
    .q_o    (res2_d)
  );

  kbs_delay #(.W(1), .N(KBS_WRAP_LAT)) u_dly_vld (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (v2),
    .q_o    (pv)
  );

  always_comb begin
    fin = res2_d;
    if (mode_q) begin
      fin.heading = wh;
      fin.steer   = ws;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || pop) begin
      out_v_q <= pv;
    end else if (pv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_d_q <= skid_d_q;
      end
    end else if (!out_v_q || pop) begin
      out_d_q <= fin;
    end else if (pv) begin
      skid_d_q <= fin;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.next_pos_x   = out_d_q.pos_x;
  assign out_o.next_pos_y   = out_d_q.pos_y;
  assign out_o.next_heading = out_d_q.heading;
  assign out_o.next_speed   = out_d_q.speed;
  assign out_o.next_accel   = out_d_q.accel;
  assign out_o.next_steer   = out_d_q.steer;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid register filled without an output stall");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_o.ready |=> skid_v_q && $stable(skid_d_q))
    else $error("skid register changed while the output was stalled");

  a_heading_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && mode_q |-> (out_d_q.heading >= -32'sd205887 &&
                           out_d_q.heading <= 32'sd205887 &&
                           out_d_q.steer >= -32'sd205887 &&
                           out_d_q.steer <= 32'sd205887))
    else $error("midpoint result angle outside the wrapped range");
endmodule

// ===== tb/tb_kinematic_bicycle_step.sv =====
// ----------------------------------------------------------------------------
// Kinematic bicycle step testbench
// Drives random and corner-case vehicle states through the step unit under
// several mode, step-length and wheel-base settings. Each output beat is
// compared field by field with a fixed-point model of the Euler and midpoint
// steps, while both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_kinematic_bicycle_step;
  timeunit 1ns;
  timeprecision 1ps;
  import kbs_pkg::*;

  localparam int     CORDIC_N   = 16;
  localparam int     WATCHDOG   = 5000;
  localparam int     DRAIN      = 200;
  localparam int     LONG_HOLD  = 400;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint PI_Q       = 205887;
  localparam longint TWO_PI_Q   = 411775;
  localparam longint HALF_PI_Q  = 102944;
  localparam longint GAIN_Q30   = 652032874;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;

  typedef struct packed {
    kbs_state_t st;
    kbs_ctrl_t  ctl;
  } step_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;

  kbs_in_if  in_ch ();
  kbs_out_if out_ch ();

  kinematic_bicycle_step #(.CORDIC_ITERATIONS(CORDIC_N)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  step_item_t pending_states[$];
  kbs_state_t expected_states[$];
  bit         mdl_mode;
  longint     mdl_dt;
  longint     mdl_iwb;
  int         errors;
  int         idle_cycles;
  bit         quiet;
  int         hold_req;
  int         hold_seen;
  int         hold_left;
  int         in_gap;
  int         out_gap;
  bit         in_taken;

  longint atan_tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                            64, 32, 16, 8, 4, 2, 1};

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint sat(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return sat((a * b) >>> 16);
  endfunction

  function automatic longint fadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint wrap(longint a);
    longint r;
    r = (a + PI_Q) % TWO_PI_Q;
    if (r < 0) r += TWO_PI_Q;
    return r - PI_Q;
  endfunction

  function automatic void trig(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = wrap(ang);
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= (i < 17) ? atan_tab[i] : 0;
      end else begin
        x += dx;
        y -= dy;
        z += (i < 17) ? atan_tab[i] : 0;
      end
    end
    s = y >>> 14;
    c = x >>> 14;
    if (flip) begin
      s = -s;
      c = -c;
    end
  endfunction

  function automatic longint tangent(longint ang);
    longint s, c;
    trig(ang, s, c);
    if (c == 0) return (s > 0) ? I32_MAX : ((s < 0) ? I32_MIN : 0);
    return sat((s * 65536) / c);
  endfunction

  function automatic void rates(input longint v[6], input longint j, input longint r,
                                output longint d[6]);
    longint s, c;
    trig(v[2], s, c);
    d[0] = fmul(v[3], c);
    d[1] = fmul(v[3], s);
    d[2] = fmul(fmul(v[3], tangent(v[5])), mdl_iwb);
    d[3] = v[4];
    d[4] = j;
    d[5] = r;
  endfunction

  function automatic kbs_state_t predict_step(step_item_t it);
    longint v[6], k1[6], k2[6], mid[6], nx[6];
    longint j, r, s, c, half;
    kbs_state_t res;
    v[0] = it.st.pos_x;
    v[1] = it.st.pos_y;
    v[2] = it.st.heading;
    v[3] = it.st.speed;
    v[4] = it.st.accel;
    v[5] = it.st.steer;
    j = it.ctl.jerk;
    r = it.ctl.steer_rate;
    if (!mdl_mode) begin
      trig(v[2], s, c);
      nx[0] = fadd(v[0], fmul(fmul(v[3], c), mdl_dt));
      nx[1] = fadd(v[1], fmul(fmul(v[3], s), mdl_dt));
      nx[2] = fadd(v[2], fmul(fmul(fmul(v[3], tangent(v[5])), mdl_iwb), mdl_dt));
      nx[3] = fadd(v[3], fmul(v[4], mdl_dt));
      nx[4] = fadd(v[4], fmul(j, mdl_dt));
      nx[5] = fadd(v[5], fmul(r, mdl_dt));
    end else begin
      half = mdl_dt >>> 1;
      rates(v, j, r, k1);
      for (int i = 0; i < 6; i++) mid[i] = fadd(v[i], fmul(half, k1[i]));
      rates(mid, j, r, k2);
      for (int i = 0; i < 6; i++) nx[i] = fadd(v[i], fmul(mdl_dt, k2[i]));
      nx[2] = wrap(nx[2]);
      nx[5] = wrap(nx[5]);
    end
    res.pos_x   = q_t'(nx[0][31:0]);
    res.pos_y   = q_t'(nx[1][31:0]);
    res.heading = q_t'(nx[2][31:0]);
    res.speed   = q_t'(nx[3][31:0]);
    res.accel   = q_t'(nx[4][31:0]);
    res.steer   = q_t'(nx[5][31:0]);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic q_t spread(longint lim);
    if ($urandom_range(0, 7) == 0) return q_t'($urandom);
    return q_t'(longint'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic step_item_t rand_item();
    step_item_t it;
    it.st.pos_x   = spread(64'd67108864);
    it.st.pos_y   = spread(64'd67108864);
    it.st.heading = spread(4 * PI_Q);
    it.st.speed   = spread(64'd1966080);
    it.st.accel   = spread(64'd327680);
    it.st.steer   = spread(64'd45875);
    if ($urandom_range(0, 15) == 0) begin
      it.st.steer = q_t'((($urandom_range(0, 1) != 0) ? HALF_PI_Q : -HALF_PI_Q)
                         + longint'($urandom_range(0, 10)) - 5);
    end
    it.ctl.jerk       = spread(64'd196608);
    it.ctl.steer_rate = spread(64'd65536);
    return it;
  endfunction

  function automatic step_item_t mk(q_t px, q_t py, q_t h, q_t v, q_t a, q_t s, q_t j, q_t r);
    step_item_t it;
    it.st  = '{px, py, h, v, a, s};
    it.ctl = '{j, r};
    return it;
  endfunction

  task automatic report(string field, q_t got, q_t want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_MODE) mdl_mode = data[0];
    else if (idx == CFG_TIME_STEP) mdl_dt = longint'(data);
    else if (idx == CFG_INV_WB) mdl_iwb = longint'(data);
  endtask

  task automatic settle();
    wait (pending_states.size() == 0 && expected_states.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic run_phase(bit m, logic [30:0] dt, logic [30:0] iwb, int n, bit hold);
    settle();
    write_reg(CFG_MODE, {30'd0, m});
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_INV_WB, iwb);
    if (hold) hold_req++;
    repeat (n) pending_states.push_back(rand_item());
  endtask

  // Input driver: a beat stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_states.size() > 0) begin
      in_ch.valid      <= 1'b1;
      in_ch.pos_x      <= pending_states[0].st.pos_x;
      in_ch.pos_y      <= pending_states[0].st.pos_y;
      in_ch.heading    <= pending_states[0].st.heading;
      in_ch.speed      <= pending_states[0].st.speed;
      in_ch.accel      <= pending_states[0].st.accel;
      in_ch.steer      <= pending_states[0].st.steer;
      in_ch.jerk       <= pending_states[0].ctl.jerk;
      in_ch.steer_rate <= pending_states[0].ctl.steer_rate;
      in_gap <= pick_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      expected_states.push_back(predict_step(pending_states[0]));
      void'(pending_states.pop_front());
    end
  end

  // Output ready, with an occasional long hold-off to back up the pipeline.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    kbs_state_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_states.size() == 0) begin
        report("unexpected beat", out_ch.next_pos_x, '0);
      end else begin
        want = expected_states.pop_front();
        if (out_ch.next_pos_x !== want.pos_x) report("next_pos_x", out_ch.next_pos_x, want.pos_x);
        if (out_ch.next_pos_y !== want.pos_y) report("next_pos_y", out_ch.next_pos_y, want.pos_y);
        if (out_ch.next_heading !== want.heading)
          report("next_heading", out_ch.next_heading, want.heading);
        if (out_ch.next_speed !== want.speed) report("next_speed", out_ch.next_speed, want.speed);
        if (out_ch.next_accel !== want.accel) report("next_accel", out_ch.next_accel, want.accel);
        if (out_ch.next_steer !== want.steer) report("next_steer", out_ch.next_steer, want.steer);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("tb_kinematic_bicycle_step NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_req    = 0;
    hold_seen   = 0;
    hold_left   = 0;
    in_gap      = 0;
    out_gap     = 0;
    in_taken    = 1'b0;
    mdl_mode    = 1'b1;
    mdl_dt      = 6554;
    mdl_iwb     = 23406;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_MODE;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    {in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.speed} = '0;
    {in_ch.accel, in_ch.steer, in_ch.jerk, in_ch.steer_rate} = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_states.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pending_states.push_back(mk(KBS_Q_MAX, KBS_Q_MAX, KBS_Q_MAX, KBS_Q_MAX, KBS_Q_MAX,
                                KBS_Q_MAX, KBS_Q_MAX, KBS_Q_MAX));
    pending_states.push_back(mk(KBS_Q_MIN, KBS_Q_MIN, KBS_Q_MIN, KBS_Q_MIN, KBS_Q_MIN,
                                KBS_Q_MIN, KBS_Q_MIN, KBS_Q_MIN));
    pending_states.push_back(mk(100, -100, q_t'(PI_Q), 65536, 0, 0, 0, 0));
    pending_states.push_back(mk(0, 0, q_t'(-PI_Q), 65536, 0, 0, 0, 0));
    pending_states.push_back(mk(0, 0, q_t'(-PI_Q - 1), 65536, 0, 0, 0, 0));
    pending_states.push_back(mk(0, 0, q_t'(HALF_PI_Q), 655360, 0, 1000, 0, 0));
    pending_states.push_back(mk(0, 0, q_t'(HALF_PI_Q + 1), 655360, 0, -1000, 0, 0));
    pending_states.push_back(mk(0, 0, q_t'(-HALF_PI_Q), 655360, 65536, 0, 0, 0));
    pending_states.push_back(mk(0, 0, 0, 655360, 0, q_t'(HALF_PI_Q), 0, 0));
    pending_states.push_back(mk(0, 0, 0, 655360, 0, q_t'(-HALF_PI_Q), 0, 0));
    pending_states.push_back(mk(0, 0, 0, KBS_Q_MAX, 0, q_t'(HALF_PI_Q), 0, 0));
    pending_states.push_back(mk(KBS_Q_MAX, KBS_Q_MIN, 0, KBS_Q_MAX, KBS_Q_MAX, 0,
                                KBS_Q_MAX, KBS_Q_MAX));
    pending_states.push_back(mk(0, 0, q_t'(3 * PI_Q), 65536, 0, q_t'(PI_Q), 0, KBS_Q_MIN));
    repeat (140) pending_states.push_back(rand_item());

    run_phase(1'b0, 31'd6554, 31'd23406, 150, 1'b1);
    run_phase(1'b0, 31'd1, 31'h7FFFFFFF, 150, 1'b0);
    quiet = 1'b1;
    run_phase(1'b1, 31'h7FFFFFFF, 31'd1, 150, 1'b0);
    settle();
    quiet = 1'b0;
    write_reg(CFG_UNUSED, 31'h7FFFFFFF);
    run_phase(1'b1, 31'd0, 31'd65536, 150, 1'b0);
    run_phase(1'b0, 31'd65536, 31'd32768, 150, 1'b1);
    run_phase(1'b1, 31'd3277, 31'd23406, 150, 1'b0);

    wait (pending_states.size() == 0 && expected_states.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_kinematic_bicycle_step OK");
    end else begin
      $display("tb_kinematic_bicycle_step NOT OK");
    end
    $finish;
  end

endmodule
